FILE: src/stbm_pkg.sv
// ----------------------------------------------------------------------------
// stbm_pkg: shared types and constants for the token boundary marker
// Character codes, lexer mode and token class codes, the response record,
// and the character classification functions.
// ----------------------------------------------------------------------------
`default_nettype none

package stbm_pkg;

   // Character codes
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_TILDE   = 8'h7E;

   // Lexer mode codes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_STR    = 2'd1;
   localparam logic [1:0] MODE_CHR    = 2'd2;

   // Open token class codes
   localparam logic [2:0] CLS_EMPTY = 3'd0;
   localparam logic [2:0] CLS_IDENT = 3'd1;
   localparam logic [2:0] CLS_DASH  = 3'd2;
   localparam logic [2:0] CLS_COLON = 3'd3;
   localparam logic [2:0] CLS_DOT1  = 3'd4;
   localparam logic [2:0] CLS_DOT2  = 3'd5;
   localparam logic [2:0] CLS_OTHER = 3'd6;

   // One response
   typedef struct packed {
      logic [7:0] out_char;
      logic       keep;
      logic       starts_token;
      logic       in_literal;
   } rsp_type;

   function automatic logic is_alpha_u(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == CH_UNDER);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha_u(c) || ((c >= 8'h30) && (c <= 8'h39));
   endfunction

   function automatic logic is_single_punct(input logic [7:0] c);
      logic r;
      case (c)
         CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
         CH_SEMI, CH_COMMA, CH_LT, CH_AMP, CH_STAR, CH_PLUS,
         CH_DASH, CH_EQ, CH_SLASH, CH_TILDE: r = 1'b1;
         default:                           r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/source_token_boundary_marker_core.sv
// ----------------------------------------------------------------------------
// source_token_boundary_marker_core: token boundary marker for C-like text
// Classifies one source byte per request: kept or dropped whitespace, start
// of a new token, and inside a string or character literal.
// ----------------------------------------------------------------------------
// One request per clock cycle, sustained while req_stall is low. Each byte is
// classified by short logic against the lexer state and is registered in the
// response register, or in the skid entry if a stalled response holds it. A
// two-entry stage (main register plus skid) decouples the sides, so req_stall
// rises only when both entries hold responses that rsp_stall has kept from
// leaving. A request with last_char set resets the lexer state for the next file.
`default_nettype none

module source_token_boundary_marker_core
   import stbm_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_ch,
   input  wire        req_last_char,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_keep,
   output logic       rsp_starts_token,
   output logic       rsp_in_literal
);

   logic [1:0] lex_mode_ff, lex_mode_in;
   logic       escape_ff, escape_in;
   logic [2:0] token_class_ff, token_class_in;

   rsp_type    rsp_ff, rsp_in;
   rsp_type    skid_ff, skid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   rsp_type    new_rsp;
   logic       req_take;
   logic       rsp_take;
   logic [1:0] mode_nx;
   logic       esc_nx;
   logic [2:0] cls_nx;
   logic [7:0] closer;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // Byte classification and lexer state update
   always_comb begin
      mode_nx              = lex_mode_ff;
      esc_nx               = escape_ff;
      cls_nx               = token_class_ff;
      new_rsp.out_char     = req_ch;
      new_rsp.keep         = 1'b1;
      new_rsp.starts_token = 1'b0;
      new_rsp.in_literal   = 1'b0;
      closer               = (lex_mode_ff == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;

      if ((lex_mode_ff == MODE_STR) || (lex_mode_ff == MODE_CHR)) begin
         new_rsp.in_literal = 1'b1;
         if (escape_ff) begin
            esc_nx = 1'b0;
         end else if (req_ch == CH_BSLASH) begin
            esc_nx = 1'b1;
         end else if (req_ch == closer) begin
            mode_nx = MODE_NORMAL;
            cls_nx  = CLS_EMPTY;
         end
      end else begin
         if ((req_ch == CH_DQUOTE) || (req_ch == CH_SQUOTE)) begin
            new_rsp.starts_token = 1'b1;
            new_rsp.in_literal   = 1'b1;
            mode_nx = (req_ch == CH_DQUOTE) ? MODE_STR : MODE_CHR;
            esc_nx  = 1'b0;
            cls_nx  = CLS_OTHER;
         end else if (is_single_punct(req_ch)) begin
            new_rsp.starts_token = 1'b1;
            cls_nx = (req_ch == CH_DASH) ? CLS_DASH : CLS_OTHER;
         end else if (req_ch == CH_GT) begin
            // "->" stays one token
            new_rsp.starts_token = (token_class_ff != CLS_DASH);
            cls_nx = CLS_OTHER;
         end else if (req_ch == CH_COLON) begin
            if (token_class_ff == CLS_COLON) begin
               cls_nx = CLS_OTHER;
            end else begin
               new_rsp.starts_token = 1'b1;
               cls_nx = CLS_COLON;
            end
         end else if (req_ch == CH_DOT) begin
            // up to three dots form one token
            if (token_class_ff == CLS_DOT1) begin
               cls_nx = CLS_DOT2;
            end else if (token_class_ff == CLS_DOT2) begin
               cls_nx = CLS_OTHER;
            end else begin
               new_rsp.starts_token = 1'b1;
               cls_nx = CLS_DOT1;
            end
         end else if ((req_ch == CH_SPACE) || (req_ch == CH_TAB)) begin
            new_rsp.keep = 1'b0;
            cls_nx = CLS_EMPTY;
         end else if (token_class_ff == CLS_IDENT) begin
            cls_nx = is_word(req_ch) ? CLS_IDENT : CLS_OTHER;
         end else begin
            new_rsp.starts_token = 1'b1;
            cls_nx = is_alpha_u(req_ch) ? CLS_IDENT : CLS_OTHER;
         end
      end

      lex_mode_in    = lex_mode_ff;
      escape_in      = escape_ff;
      token_class_in = token_class_ff;
      if (req_take) begin
         if (req_last_char) begin
            lex_mode_in    = MODE_NORMAL;
            escape_in      = 1'b0;
            token_class_in = CLS_EMPTY;
         end else begin
            lex_mode_in    = mode_nx;
            escape_in      = esc_nx;
            token_class_in = cls_nx;
         end
      end
   end

   // Response register and skid entry
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (req_take) begin
            rsp_in = new_rsp;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (rsp_valid_ff) begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end else begin
            rsp_in       = new_rsp;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_mode_ff    <= MODE_NORMAL;
         escape_ff      <= 1'b0;
         token_class_ff <= CLS_EMPTY;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         lex_mode_ff    <= lex_mode_in;
         escape_ff      <= escape_in;
         token_class_ff <= token_class_in;
         rsp_valid_ff   <= rsp_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_ff.out_char;
   assign rsp_keep         = rsp_ff.keep;
   assign rsp_starts_token = rsp_ff.starts_token;
   assign rsp_in_literal   = rsp_ff.in_literal;

endmodule

`default_nettype wire

FILE: src/stbm_checker.sv
// ----------------------------------------------------------------------------
// stbm_checker: port-level checks for the token boundary marker
// Watches the response channel and the reset behavior of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module stbm_checker
   import stbm_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       req_stall,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [7:0] rsp_out_char,
   input wire       rsp_keep,
   input wire       rsp_starts_token,
   input wire       rsp_in_literal
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_keep)
         && $stable(rsp_starts_token) && $stable(rsp_in_literal))
      else $error("stalled response changed");

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response pending after reset");

   // A dropped byte never opens a token or sits in a literal
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_keep |-> !rsp_starts_token && !rsp_in_literal)
      else $error("dropped byte flagged as token or literal");

   // Space or tab outside a literal is always dropped
   a_ws_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_literal && ((rsp_out_char == CH_SPACE) || (rsp_out_char == CH_TAB))
         |-> !rsp_keep)
      else $error("whitespace kept outside literal");

   // A quote byte is always part of a literal
   a_quote_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_out_char == CH_DQUOTE) || (rsp_out_char == CH_SQUOTE))
         |-> rsp_in_literal)
      else $error("quote outside literal");

endmodule

bind source_token_boundary_marker_core stbm_checker u_stbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_char     (rsp_out_char),
   .rsp_keep         (rsp_keep),
   .rsp_starts_token (rsp_starts_token),
   .rsp_in_literal   (rsp_in_literal)
);

`default_nettype wire
